[rtl/ball_wall_bounce_step_defines.svh]
// assertion macros for the ball wall bounce step block
// used by the top level only, needs clk_i and rst_ni in scope
`ifndef BALL_WALL_BOUNCE_STEP_DEFINES_SVH
`define BALL_WALL_BOUNCE_STEP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BWB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BWB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BWB_ASSERT(lbl, prop, msg)
`define BWB_ASSERT_RST(lbl, prop, msg)
`endif
`endif

[rtl/bwb_pkg.sv]
// types, constants and saturation helper of the ball wall bounce step block
// no dependencies
`default_nettype none
package bwb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ELAST_BITS    = 16;

  localparam logic signed [31:0] GRAVITY_RST = 32'sd26214;
  localparam logic [14:0]        HEIGHT_RST  = 15'd850;
  localparam logic [14:0]        WIDTH_RST   = 15'd1200;
  localparam logic [30:0]        STOP_RST    = 31'd22348;

  typedef enum logic [1:0] {
    CFG_GRAVITY = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_WIDTH   = 2'd2,
    CFG_STOP    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        ball_radius;
    logic [16:0]        bounce_factor;
    logic [30:0]        ball_mass;
    logic [30:0]        friction_force;
  } ball_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
  } res_t;

  typedef struct packed {
    logic signed [31:0] gravity_accel;
    logic [14:0]        screen_height;
    logic [14:0]        screen_width;
    logic [30:0]        stop_threshold;
  } cfg_t;

  localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7FFF_FFFF;
    else if (v < SAT_MIN) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/bwb_if.sv]
// stream interfaces of the ball wall bounce step block: ball in, result out, config
// no dependencies
`default_nettype none
interface bwb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic [30:0]        ball_radius;
  logic [16:0]        bounce_factor;
  logic [30:0]        ball_mass;
  logic [30:0]        friction_force;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, ball_radius, bounce_factor,
                  ball_mass, friction_force, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, ball_radius, bounce_factor,
                ball_mass, friction_force, output ready);
endinterface

interface bwb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, input ready);
  modport sink (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y, output ready);
endinterface

interface bwb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/bwb_div.sv]
// pipelined restoring divider for friction deceleration, one quotient bit a stage
// carries the ball word alongside; depends on bwb_pkg
`default_nettype none
module bwb_div #(
  parameter int FRAC_BITS = bwb_pkg::FRAC_BITS_DEF
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       en_i,
  input  wire                       valid_i,
  input  bwb_pkg::ball_t            ball_i,
  output logic                      valid_o,
  output bwb_pkg::ball_t            ball_o,
  output logic [31+FRAC_BITS-1:0]   acc_o
);
  localparam int QW = 31 + FRAC_BITS;

  logic                 v_w   [QW+1];
  logic [30:0]          rem_w [QW+1];
  logic [QW-1:0]        quo_w [QW+1];
  bwb_pkg::ball_t       ball_w[QW+1];

  assign v_w[0]    = valid_i;
  assign rem_w[0]  = '0;
  assign quo_w[0]  = '0;
  assign ball_w[0] = ball_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic          dbit;
    logic [31:0]   t;
    logic          ge;
    logic [30:0]   rem_d;
    logic [QW-1:0] quo_d;
    logic          v_q;
    logic [30:0]   rem_q;
    logic [QW-1:0] quo_q;
    bwb_pkg::ball_t ball_q;

    if (B >= FRAC_BITS) begin : g_bit
      assign dbit = ball_w[k].friction_force[B-FRAC_BITS];
    end else begin : g_zero
      assign dbit = 1'b0;
    end

    always_comb begin
      t     = {rem_w[k], dbit};
      ge    = t >= {1'b0, ball_w[k].ball_mass};
      rem_d = ge ? 31'(t - {1'b0, ball_w[k].ball_mass}) : t[30:0];
      quo_d = quo_w[k];
      quo_d[B] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        quo_q  <= quo_d;
        ball_q <= ball_w[k];
      end
    end

    assign v_w[k+1]    = v_q;
    assign rem_w[k+1]  = rem_q;
    assign quo_w[k+1]  = quo_q;
    assign ball_w[k+1] = ball_q;
  end

  assign valid_o = v_w[QW];
  assign ball_o  = ball_w[QW];
  assign acc_o   = quo_w[QW];
endmodule
`default_nettype wire

[rtl/bwb_phys.sv]
// motion, floor, ceiling and side wall pipeline, six register stages
// depends on bwb_pkg
`default_nettype none
module bwb_phys #(
  parameter int FRAC_BITS = bwb_pkg::FRAC_BITS_DEF
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      en_i,
  input  wire                      valid_i,
  input  bwb_pkg::ball_t           ball_i,
  input  wire [31+FRAC_BITS-1:0]   acc_i,
  input  bwb_pkg::cfg_t            cfg_i,
  output logic                     valid_o,
  output bwb_pkg::res_t            res_o
);
  localparam int QW = 31 + FRAC_BITS;
  localparam int WW = (FRAC_BITS + 17 > 33) ? FRAC_BITS + 17 : 33;

  logic [5:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end
  assign valid_o = v_q[5];

  // stage 1: gravity, floor line
  logic signed [31:0] x1_q, y1_q, vx1_q, vy1_q;
  logic [30:0]        r1_q;
  logic [16:0]        e1_q;
  logic [QW-1:0]      acc1_q;
  logic signed [WW-1:0] fl1_q;
  logic signed [WW-1:0] hgt, fl_d;

  always_comb begin
    hgt  = $signed({{(WW-15-FRAC_BITS){1'b0}}, cfg_i.screen_height, {FRAC_BITS{1'b0}}});
    fl_d = hgt - $signed({{(WW-31){1'b0}}, ball_i.ball_radius});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= ball_i.pos_x;
      y1_q   <= ball_i.pos_y;
      vx1_q  <= ball_i.vel_x;
      vy1_q  <= bwb_pkg::sat32(64'(ball_i.vel_y) + 64'(cfg_i.gravity_accel));
      r1_q   <= ball_i.ball_radius;
      e1_q   <= ball_i.bounce_factor;
      acc1_q <= acc_i;
      fl1_q  <= fl_d;
    end
  end

  // stage 2: move down, floor test, damping product
  logic signed [31:0] x2_q, y2_q, vx2_q, vy2_q;
  logic [30:0]        r2_q;
  logic [16:0]        e2_q;
  logic [QW-1:0]      acc2_q;
  logic signed [WW-1:0] fl2_q;
  logic               floor2_q, neg2_q;
  logic [32:0]        p2_q;
  logic signed [31:0] y2_d;
  logic [31:0]        mag2;
  logic [48:0]        prod2;

  always_comb begin
    y2_d  = bwb_pkg::sat32(64'(y1_q) + 64'(vy1_q));
    mag2  = vy1_q[31] ? 32'(-vy1_q) : 32'(vy1_q);
    prod2 = 49'(mag2) * 49'(e1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q     <= x1_q;
      y2_q     <= y2_d;
      vx2_q    <= vx1_q;
      vy2_q    <= vy1_q;
      r2_q     <= r1_q;
      e2_q     <= e1_q;
      acc2_q   <= acc1_q;
      fl2_q    <= fl1_q;
      floor2_q <= $signed(WW'(y2_d)) >= fl1_q;
      neg2_q   <= vy1_q > 32'sd0;
      p2_q     <= prod2[48:bwb_pkg::ELAST_BITS];
    end
  end

  // stage 3: floor clamp, stop test, friction
  logic signed [31:0] x3_q, y3_q, vx3_q, vy3_q;
  logic [30:0]        r3_q;
  logic [16:0]        e3_q;
  logic signed [31:0] d3, vy3_d, vx3_d, fr3;
  logic [32:0]        magd3, magvx3;
  logic [63:0]        acc64;

  always_comb begin
    d3     = bwb_pkg::sat32(neg2_q ? -$signed(64'(p2_q)) : $signed(64'(p2_q)));
    magd3  = d3[31] ? 33'(-$signed({d3[31], d3})) : 33'(d3);
    vy3_d  = floor2_q ? ((magd3 < 33'(cfg_i.stop_threshold)) ? 32'sd0 : d3) : vy2_q;
    acc64  = 64'(acc2_q);
    magvx3 = 33'(-$signed({vx2_q[31], vx2_q}));
    if (vx2_q > 32'sd0) begin
      fr3 = (acc64 >= 64'(vx2_q)) ? 32'sd0 : 32'(vx2_q - $signed(acc2_q[31:0]));
    end else if (vx2_q < 32'sd0) begin
      fr3 = (acc64 >= 64'(magvx3)) ? 32'sd0 : 32'(vx2_q + $signed(acc2_q[31:0]));
    end else begin
      fr3 = vx2_q;
    end
    vx3_d = floor2_q ? fr3 : vx2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x3_q  <= x2_q;
      y3_q  <= floor2_q ? bwb_pkg::sat32(64'(fl2_q)) : y2_q;
      vx3_q <= vx3_d;
      vy3_q <= vy3_d;
      r3_q  <= r2_q;
      e3_q  <= e2_q;
    end
  end

  // stage 4: ceiling test and product, move sideways, right wall line
  logic signed [31:0] x4_q, y4_q, vx4_q, vy4_q;
  logic [30:0]        r4_q;
  logic               ceil4_q, neg4_q;
  logic [32:0]        p4_q;
  logic signed [WW-1:0] wr4_q;
  logic               ceil4_d;
  logic [31:0]        mag4;
  logic [48:0]        prod4;
  logic signed [WW-1:0] wid;

  always_comb begin
    ceil4_d = $signed({y3_q[31], y3_q}) <= $signed({2'b00, r3_q});
    mag4    = vy3_q[31] ? 32'(-vy3_q) : 32'(vy3_q);
    prod4   = 49'(mag4) * 49'(e3_q);
    wid     = $signed({{(WW-15-FRAC_BITS){1'b0}}, cfg_i.screen_width, {FRAC_BITS{1'b0}}});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x4_q    <= bwb_pkg::sat32(64'(x3_q) + 64'(vx3_q));
      y4_q    <= ceil4_d ? $signed({1'b0, r3_q}) : y3_q;
      vx4_q   <= vx3_q;
      vy4_q   <= vy3_q;
      r4_q    <= r3_q;
      ceil4_q <= ceil4_d;
      neg4_q  <= vy3_q > 32'sd0;
      p4_q    <= prod4[48:bwb_pkg::ELAST_BITS];
      wr4_q   <= wid - $signed({{(WW-31){1'b0}}, r3_q});
    end
  end

  // stage 5: ceiling damping, right wall
  logic signed [31:0] x5_q, y5_q, vx5_q, vy5_q;
  logic [30:0]        r5_q;
  logic               right5;

  always_comb begin
    right5 = $signed(WW'(x4_q)) >= wr4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vy5_q <= ceil4_q ?
               bwb_pkg::sat32(neg4_q ? -$signed(64'(p4_q)) : $signed(64'(p4_q))) : vy4_q;
      x5_q  <= right5 ? bwb_pkg::sat32((64'(wr4_q) <<< 1) - 64'(x4_q)) : x4_q;
      vx5_q <= right5 ? bwb_pkg::sat32(-64'(vx4_q)) : vx4_q;
      y5_q  <= y4_q;
      r5_q  <= r4_q;
    end
  end

  // stage 6: left wall, output word
  logic left6;

  always_comb begin
    left6 = $signed({x5_q[31], x5_q}) <= $signed({2'b00, r5_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.new_pos_x <= left6 ?
                         bwb_pkg::sat32($signed(64'(r5_q) <<< 1) - 64'(x5_q)) : x5_q;
      res_o.new_vel_x <= left6 ? bwb_pkg::sat32(-64'(vx5_q)) : vx5_q;
      res_o.new_pos_y <= y5_q;
      res_o.new_vel_y <= vy5_q;
    end
  end
endmodule
`default_nettype wire

[rtl/ball_wall_bounce_step.sv]
// channel    dir  modport  fields
// ball_in    in   sink     pos_x pos_y vel_x vel_y ball_radius bounce_factor ball_mass friction_force
// ball_out   out  source   new_pos_x new_pos_y new_vel_x new_vel_y
// cfg        in   sink     index data
// one ball word per cycle while the output is not stalled; the friction divider resolves
// one quotient bit per stage and feeds the physics stages
// the whole pipeline holds while a finished result waits, nothing is dropped or repeated
// reset clears valid bits and loads the default register values; cfg is always ready
// top level of the ball wall bounce step block; depends on bwb_pkg, bwb_if, bwb_div, bwb_phys
`include "ball_wall_bounce_step_defines.svh"
`default_nettype none
module ball_wall_bounce_step #(
  parameter int FRAC_BITS = bwb_pkg::FRAC_BITS_DEF
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  bwb_in_if.sink    ball_in,
  bwb_out_if.source ball_out,
  bwb_cfg_if.sink   cfg
);
  bwb_pkg::cfg_t  cfg_q;
  bwb_pkg::ball_t ball_w, div_ball;
  bwb_pkg::res_t  res;
  logic           en, div_valid, out_valid;
  logic [31+FRAC_BITS-1:0] acc;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gravity_accel  <= bwb_pkg::GRAVITY_RST;
      cfg_q.screen_height  <= bwb_pkg::HEIGHT_RST;
      cfg_q.screen_width   <= bwb_pkg::WIDTH_RST;
      cfg_q.stop_threshold <= bwb_pkg::STOP_RST;
    end else if (cfg.valid) begin
      unique case (bwb_pkg::cfg_idx_e'(cfg.index))
        bwb_pkg::CFG_GRAVITY: cfg_q.gravity_accel  <= cfg.data;
        bwb_pkg::CFG_HEIGHT:  cfg_q.screen_height  <= cfg.data[14:0];
        bwb_pkg::CFG_WIDTH:   cfg_q.screen_width   <= cfg.data[14:0];
        bwb_pkg::CFG_STOP:    cfg_q.stop_threshold <= cfg.data[30:0];
        default: ;
      endcase
    end
  end

  assign en            = !out_valid || ball_out.ready;
  assign ball_in.ready = en;

  always_comb begin
    ball_w.pos_x          = ball_in.pos_x;
    ball_w.pos_y          = ball_in.pos_y;
    ball_w.vel_x          = ball_in.vel_x;
    ball_w.vel_y          = ball_in.vel_y;
    ball_w.ball_radius    = ball_in.ball_radius;
    ball_w.bounce_factor  = ball_in.bounce_factor;
    ball_w.ball_mass      = ball_in.ball_mass;
    ball_w.friction_force = ball_in.friction_force;
  end

  bwb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ball_in.valid),
    .ball_i  (ball_w),
    .valid_o (div_valid),
    .ball_o  (div_ball),
    .acc_o   (acc)
  );

  bwb_phys #(.FRAC_BITS(FRAC_BITS)) u_phys (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .ball_i  (div_ball),
    .acc_i   (acc),
    .cfg_i   (cfg_q),
    .valid_o (out_valid),
    .res_o   (res)
  );

  assign ball_out.valid     = out_valid;
  assign ball_out.new_pos_x = res.new_pos_x;
  assign ball_out.new_pos_y = res.new_pos_y;
  assign ball_out.new_vel_x = res.new_vel_x;
  assign ball_out.new_vel_y = res.new_vel_y;

  `BWB_ASSERT(a_ready_when_empty, !ball_out.valid |-> ball_in.ready, "input stalled with empty output")
  `BWB_ASSERT(a_stall_holds_pipe, ball_out.valid && !ball_out.ready |=> ball_out.valid && !ball_in.ready || ball_out.ready, "stalled result lost")
  `BWB_ASSERT_RST(a_reset_empty, !rst_ni |-> !ball_out.valid, "result valid during reset")
endmodule
`default_nettype wire

[test/tb_bwb_scoreboard.sv]
// scoreboard class for the ball wall bounce step testbench
// holds the step predictor and the queue of expected result words, depends on bwb_pkg
class bwb_scoreboard;
  bwb_pkg::cfg_t   cfg;
  bwb_pkg::res_t   pending[$];
  int              errors;

  function new();
    cfg.gravity_accel  = bwb_pkg::GRAVITY_RST;
    cfg.screen_height  = bwb_pkg::HEIGHT_RST;
    cfg.screen_width   = bwb_pkg::WIDTH_RST;
    cfg.stop_threshold = bwb_pkg::STOP_RST;
    errors = 0;
  endfunction

  function automatic longint clip(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint bounce(longint v, longint e);
    longint n, mag;
    n = -v;
    mag = (n < 0) ? -n : n;
    mag = (mag * e) >>> 16;
    return clip((n < 0) ? -mag : mag);
  endfunction

  function void write_reg(bwb_pkg::cfg_idx_e idx, logic [31:0] d);
    case (idx)
      bwb_pkg::CFG_GRAVITY: cfg.gravity_accel = d;
      bwb_pkg::CFG_HEIGHT:  cfg.screen_height = d[14:0];
      bwb_pkg::CFG_WIDTH:   cfg.screen_width = d[14:0];
      bwb_pkg::CFG_STOP:    cfg.stop_threshold = d[30:0];
      default: ;
    endcase
  endfunction

  function void note_ball(bwb_pkg::ball_t b);
    longint x, y, vx, vy, r, e, m, f, hgt, wid, mag, acc;
    bwb_pkg::res_t o;
    x = b.pos_x; y = b.pos_y; vx = b.vel_x; vy = b.vel_y;
    r = b.ball_radius; e = b.bounce_factor; m = b.ball_mass; f = b.friction_force;
    hgt = longint'(cfg.screen_height) <<< 16;
    wid = longint'(cfg.screen_width) <<< 16;
    vy = clip(vy + longint'(cfg.gravity_accel));
    y = clip(y + vy);
    if (y >= hgt - r) begin
      y = clip(hgt - r);
      vy = bounce(vy, e);
      mag = (vy < 0) ? -vy : vy;
      if (mag < longint'(cfg.stop_threshold)) vy = 0;
      if (m == 0) begin
        vx = 0;
      end else begin
        acc = (f <<< 16) / m;
        if (vx > 0) vx = (acc >= vx) ? 0 : vx - acc;
        else if (vx < 0) vx = (acc >= -vx) ? 0 : vx + acc;
      end
    end
    if (y <= r) begin
      y = r;
      vy = bounce(vy, e);
    end
    x = clip(x + vx);
    if (x >= wid - r) begin
      x = clip(2 * (wid - r) - x);
      vx = clip(-vx);
    end
    if (x <= r) begin
      x = clip(2 * r - x);
      vx = clip(-vx);
    end
    o.new_pos_x = x[31:0];
    o.new_pos_y = y[31:0];
    o.new_vel_x = vx[31:0];
    o.new_vel_y = vy[31:0];
    pending.push_back(o);
  endfunction

  function void check_result(bwb_pkg::res_t got);
    bwb_pkg::res_t w;
    if (pending.size() == 0) begin
      $error("result word with nothing expected");
      errors++;
      return;
    end
    w = pending.pop_front();
    if (got.new_pos_x !== w.new_pos_x) begin
      $error("new_pos_x expected %0d got %0d", w.new_pos_x, got.new_pos_x); errors++;
    end
    if (got.new_pos_y !== w.new_pos_y) begin
      $error("new_pos_y expected %0d got %0d", w.new_pos_y, got.new_pos_y); errors++;
    end
    if (got.new_vel_x !== w.new_vel_x) begin
      $error("new_vel_x expected %0d got %0d", w.new_vel_x, got.new_vel_x); errors++;
    end
    if (got.new_vel_y !== w.new_vel_y) begin
      $error("new_vel_y expected %0d got %0d", w.new_vel_y, got.new_vel_y); errors++;
    end
  endfunction
endclass

[test/tb_ball_wall_bounce_step.sv]
// testbench top for the ball wall bounce step block
// drives ball, result and config channels; depends on bwb_pkg, bwb_if, tb_bwb_scoreboard, ball_wall_bounce_step
module tb_ball_wall_bounce_step;

  logic clk_i = 1'b0;
  logic rst_ni;
  bwb_in_if  ball_in();
  bwb_out_if ball_out();
  bwb_cfg_if cfg();
  bwb_scoreboard sb = new();
  bit sink_stall_on = 1'b1;

  ball_wall_bounce_step DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .ball_in(ball_in), .ball_out(ball_out), .cfg(cfg)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    ball_in.valid = 1'b0;
    {ball_in.pos_x, ball_in.pos_y, ball_in.vel_x, ball_in.vel_y} = '0;
    {ball_in.ball_radius, ball_in.bounce_factor, ball_in.ball_mass} = '0;
    ball_in.friction_force = '0;
    ball_out.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = bwb_pkg::CFG_GRAVITY;
    cfg.data = '0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  always @(posedge clk_i) begin
    if (ball_out.valid && ball_out.ready) begin
      sb.check_result({ball_out.new_pos_x, ball_out.new_pos_y,
                       ball_out.new_vel_x, ball_out.new_vel_y});
    end
  end

  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (wait_n > 0) begin
        ball_out.ready <= 1'b0;
        wait_n--;
      end else begin
        ball_out.ready <= 1'b1;
        if (sink_stall_on && $urandom_range(0, 3) == 0) wait_n = gap_len();
      end
    end
  end

  task automatic write_reg(bwb_pkg::cfg_idx_e idx, logic [31:0] d);
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= d;
    do @(posedge clk_i); while (!cfg.ready);
    sb.write_reg(idx, d);
    cfg.valid <= 1'b0;
  endtask

  // called at a rising edge, drives the word at that edge unless a random gap is inserted first
  task automatic send_ball(bwb_pkg::ball_t b, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      ball_in.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    ball_in.valid <= 1'b1;
    {ball_in.pos_x, ball_in.pos_y, ball_in.vel_x, ball_in.vel_y, ball_in.ball_radius,
     ball_in.bounce_factor, ball_in.ball_mass, ball_in.friction_force} <= b;
    do @(posedge clk_i); while (!ball_in.ready);
    sb.note_ball(b);
  endtask

  task automatic drain();
    ball_in.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic bwb_pkg::ball_t mk(int x, int y, int vx, int vy, int r, int e, int m,
                                        int f);
    bwb_pkg::ball_t b;
    b.pos_x = x; b.pos_y = y; b.vel_x = vx; b.vel_y = vy;
    b.ball_radius = 31'(r); b.bounce_factor = 17'(e); b.ball_mass = 31'(m);
    b.friction_force = 31'(f);
    return b;
  endfunction

  function automatic bwb_pkg::ball_t rand_ball(bit wild);
    bwb_pkg::ball_t b;
    int unsigned h, w;
    h = 32'(sb.cfg.screen_height);
    w = 32'(sb.cfg.screen_width);
    if (wild) begin
      b.pos_x = $urandom; b.pos_y = $urandom; b.vel_x = $urandom; b.vel_y = $urandom;
      b.ball_radius = 31'($urandom);
      b.bounce_factor = 17'($urandom);
      b.ball_mass = 31'($urandom);
      b.friction_force = 31'($urandom);
      if ($urandom_range(0, 1)) b.bounce_factor = 17'($urandom_range(0, 65536));
      if ($urandom_range(0, 3) == 0) b.ball_mass = 0;
      return b;
    end
    b.ball_radius = 31'($urandom_range(0, 40) << 16 | $urandom_range(0, 65535));
    b.pos_x = $urandom_range(0, w) << 16 | $urandom_range(0, 65535);
    b.pos_y = ($urandom_range(0, 3) == 0) ? (h << 16) - b.ball_radius - $urandom_range(0, 300000)
                                          : ($urandom_range(0, h) << 16);
    b.vel_x = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
    b.vel_y = $signed($urandom_range(0, 40 << 16)) - (20 << 16);
    b.bounce_factor = 17'($urandom_range(0, 65536));
    b.ball_mass = 31'($urandom_range(1, 10 << 16));
    b.friction_force = 31'($urandom_range(0, 4 << 16));
    return b;
  endfunction

  initial begin
    int n;
    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_ball(mk(100 << 16, 100 << 16, 3 << 16, 2 << 16, 10 << 16, 52429, 1 << 16, 1 << 14), 0);
    // ball just above the floor line with friction and stop settings, no floor hit
    send_ball(mk(600 << 16, 839 << 16, 5 << 16, 0, 10 << 16, 16384, 2 << 16, 3 << 16), 0);
    // zero mass on the floor
    send_ball(mk(600 << 16, 845 << 16, -7 << 16, 8 << 16, 5 << 16, 65536, 0, 1 << 16), 0);
    // friction larger than speed
    send_ball(mk(600 << 16, 845 << 16, -1 << 16, 8 << 16, 5 << 16, 65536, 1 << 16, 9 << 16), 0);
    // elasticity above one
    send_ball(mk(600 << 16, 845 << 16, 0, 32'h7fff0000, 5 << 16, 131071, 1, 0), 0);
    // ceiling
    send_ball(mk(600 << 16, 2 << 16, 0, -9 << 16, 5 << 16, 45000, 1, 0), 0);
    // floor and ceiling both
    send_ball(mk(600 << 16, 0, 0, 0, 32'h7fffffff, 65536, 1, 0), 0);
    // side walls, both
    send_ball(mk(1198 << 16, 400 << 16, 9 << 16, 0, 3 << 16, 0, 1, 0), 0);
    send_ball(mk(1 << 16, 400 << 16, -9 << 16, 0, 3 << 16, 0, 1, 0), 0);
    send_ball(mk(600 << 16, 400 << 16, 0, 0, 32'h7fffffff, 0, 32'h7fffffff, 32'h7fffffff), 0);
    // most negative and most positive velocities and extreme positions
    send_ball(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 1, 0), 0);
    send_ball(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 65536, 1, 0), 0);
    send_ball(mk(32'hffffffff, 32'hffffffff, 32'h80000000, 32'h7fffffff,
                 32'h7fffffff, 131071, 32'h7fffffff, 32'h7fffffff), 0);
    send_ball(mk(500 << 16, 845 << 16, 32'h80000000, 0, 0, 65536, 0, 0), 0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(bwb_pkg::CFG_GRAVITY, 32'h80000000);
          write_reg(bwb_pkg::CFG_HEIGHT, 32'hffff8001);
          write_reg(bwb_pkg::CFG_WIDTH, 1); write_reg(bwb_pkg::CFG_STOP, 0);
        end
        1: begin
          write_reg(bwb_pkg::CFG_GRAVITY, 32'h7fffffff); write_reg(bwb_pkg::CFG_HEIGHT, 32'h7fff);
          write_reg(bwb_pkg::CFG_WIDTH, 32'h7fff); write_reg(bwb_pkg::CFG_STOP, 32'h7fffffff);
        end
        2: begin
          write_reg(bwb_pkg::CFG_GRAVITY, $urandom);
          write_reg(bwb_pkg::CFG_HEIGHT, $urandom_range(1, 32767));
          write_reg(bwb_pkg::CFG_WIDTH, $urandom_range(1, 32767));
          write_reg(bwb_pkg::CFG_STOP, $urandom);
        end
        3: begin
          write_reg(bwb_pkg::CFG_GRAVITY, 32'hffff0000); write_reg(bwb_pkg::CFG_HEIGHT, 480);
          write_reg(bwb_pkg::CFG_WIDTH, 640); write_reg(bwb_pkg::CFG_STOP, 1 << 16);
        end
        default: begin
          write_reg(bwb_pkg::CFG_GRAVITY, 26214); write_reg(bwb_pkg::CFG_HEIGHT, 850);
          write_reg(bwb_pkg::CFG_WIDTH, 1200); write_reg(bwb_pkg::CFG_STOP, 22348);
        end
      endcase
      sink_stall_on = (ph != 3);
      n = 0;
      while (n < 80) begin
        send_ball(rand_ball($urandom_range(0, 4) == 0), (ph == 3) || ($urandom_range(0, 1) == 0));
        n++;
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
